// ===== src/layer_stack_order_table_defines.svh =====
// Assertion macros used by the layer stack order table back end
`ifndef LAYER_STACK_ORDER_TABLE_DEFINES_SVH
`define LAYER_STACK_ORDER_TABLE_DEFINES_SVH

// invariant checked at every edge outside reset
`define LSOT_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// consequent checked in the same cycle as the antecedent
`define LSOT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define LSOT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/lsot_pkg.sv =====
// Package: types and constants of the layer stack order table
package lsot_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int CMD_DEPTH     = 2;
    localparam int RES_DEPTH     = 2;

    localparam logic signed [4:0] NH_HIDDEN = 5'sb11111;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_SET   = 2'd1,
        OP_FREE  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        CMD_ALLOC,
        CMD_FAIL,
        CMD_SET,
        CMD_FREE,
        CMD_REJECT,
        CMD_REJECT_OOR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [3:0]        slot;
        logic signed [7:0] req;
    } cmd_t;

    typedef struct packed {
        logic              ok;
        logic [3:0]        slot_out;
        logic signed [4:0] new_height;
        logic signed [4:0] top_height;
    } res_t;

endpackage

// ===== src/lsot_fifo.sv =====
// Small register FIFO used between front, back and the result port
module lsot_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== src/lsot_front.sv =====
// Front end: owns the slot pool, grants and releases slots, classifies each beat
module lsot_front #(
    parameter int NUM_SLOTS = lsot_pkg::NUM_SLOTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [1:0]        op,
    input  logic [3:0]        slot,
    input  logic signed [7:0] requested_height,
    output lsot_pkg::cmd_t    cmd
);
    import lsot_pkg::*;

    localparam int SW = $clog2(NUM_SLOTS);

    logic [NUM_SLOTS-1:0] in_use_reg, in_use_next, in_use_upd;
    logic [SW-1:0]        grant;
    logic [SW-1:0]        idx;
    logic                 found;
    logic                 oor;

    assign idx = SW'(slot);
    assign oor = (32'(slot) >= NUM_SLOTS);

    // lowest free slot
    always_comb
    begin
        found = 1'b0;
        grant = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (!in_use_reg[i])
            begin
                found = 1'b1;
                grant = SW'(i);
            end
        end
    end

    always_comb
    begin
        in_use_upd = in_use_reg;
        cmd.kind   = CMD_REJECT;
        cmd.slot   = slot;
        cmd.req    = requested_height;
        case (op)
            OP_ALLOC:
            begin
                if (found)
                begin
                    cmd.kind          = CMD_ALLOC;
                    cmd.slot          = 4'(grant);
                    in_use_upd[grant] = 1'b1;
                end
                else
                begin
                    cmd.kind = CMD_FAIL;
                    cmd.slot = '0;
                end
            end
            OP_SET:
            begin
                if (oor)
                    cmd.kind = CMD_REJECT_OOR;
                else if (in_use_reg[idx])
                    cmd.kind = CMD_SET;
            end
            OP_FREE:
            begin
                if (oor)
                    cmd.kind = CMD_REJECT_OOR;
                else if (in_use_reg[idx])
                begin
                    cmd.kind        = CMD_FREE;
                    in_use_upd[idx] = 1'b0;
                end
            end
            default:
            begin
                cmd.kind = oor ? CMD_REJECT_OOR : CMD_REJECT;
            end
        endcase
        in_use_next = take ? in_use_upd : in_use_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_use_reg <= '0;
        else
            in_use_reg <= in_use_next;
    end

endmodule

// ===== src/lsot_back.sv =====
// Back end: stack order and per-slot heights, one command per cycle unless the result queue is full
`include "layer_stack_order_table_defines.svh"

module lsot_back #(
    parameter int NUM_SLOTS = lsot_pkg::NUM_SLOTS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_empty,
    input  lsot_pkg::cmd_t cmd,
    output logic           cmd_pop,
    input  logic           res_full,
    output lsot_pkg::res_t res,
    output logic           res_push
);
    import lsot_pkg::*;

    localparam int SW = $clog2(NUM_SLOTS);
    localparam int HW = SW + 1;
    localparam int CW = ((HW > 8) ? HW : 8) + 1;

    localparam logic signed [HW-1:0] ONE  = HW'(1);
    localparam logic signed [HW-1:0] NEG1 = HW'(-1);

    logic signed [HW-1:0] h_reg [NUM_SLOTS];
    logic signed [HW-1:0] h_next [NUM_SLOTS];
    logic [SW-1:0]        order_reg [NUM_SLOTS];
    logic [SW-1:0]        order_next [NUM_SLOTS];
    logic signed [HW-1:0] top_reg, top_next;

    logic [SW-1:0]        idx;
    logic signed [HW-1:0] old_h, lim, tgt;
    logic signed [CW-1:0] req_w, lim_w;
    logic                 active, is_move, is_remove, is_insert;
    logic [SW:0]          shown_cnt;

    assign cmd_pop  = !cmd_empty && !res_full;
    assign res_push = cmd_pop;

    assign idx   = SW'(cmd.slot);
    assign old_h = h_reg[idx];

    // clamp to -1..top for a shown layer, -1..top+1 for a hidden one; a free always targets -1
    always_comb
    begin
        lim   = (old_h >= 0) ? top_reg : top_reg + ONE;
        req_w = CW'(cmd.req);
        lim_w = CW'(lim);
        if (cmd.kind == CMD_FREE)
            tgt = NEG1;
        else if (req_w > lim_w)
            tgt = lim;
        else if (req_w < -1)
            tgt = NEG1;
        else
            tgt = HW'(req_w);
    end

    assign active    = cmd_pop && ((cmd.kind == CMD_SET) || (cmd.kind == CMD_FREE))
                       && (tgt != old_h);
    assign is_move   = (old_h >= 0) && (tgt >= 0);
    assign is_remove = (old_h >= 0) && (tgt < 0);
    assign is_insert = (old_h < 0);

    // renumber every slot in parallel
    always_comb
    begin
        for (int j = 0; j < NUM_SLOTS; j++)
        begin
            h_next[j] = h_reg[j];
            if (active)
            begin
                if (SW'(j) == idx)
                    h_next[j] = tgt;
                else if (is_move && (old_h > tgt))
                begin
                    if ((h_reg[j] >= tgt) && (h_reg[j] < old_h))
                        h_next[j] = h_reg[j] + ONE;
                end
                else if (is_move)
                begin
                    if ((h_reg[j] > old_h) && (h_reg[j] <= tgt))
                        h_next[j] = h_reg[j] - ONE;
                end
                else if (is_remove)
                begin
                    if (h_reg[j] > old_h)
                        h_next[j] = h_reg[j] - ONE;
                end
                else if (h_reg[j] >= tgt)
                begin
                    h_next[j] = h_reg[j] + ONE;
                end
            end
        end
    end

    // stack positions in the shifted range take a neighbour's entry; the target position takes the slot
    always_comb
    begin
        for (int p = 0; p < NUM_SLOTS; p++)
        begin
            order_next[p] = order_reg[p];
            if (active)
            begin
                if (!is_remove && (HW'(p) == tgt))
                    order_next[p] = idx;
                else if (is_move && (old_h > tgt))
                begin
                    if ((HW'(p) > tgt) && (HW'(p) <= old_h))
                        order_next[p] = order_reg[(p == 0) ? 0 : p - 1];
                end
                else if (is_move)
                begin
                    if ((HW'(p) >= old_h) && (HW'(p) < tgt))
                        order_next[p] = order_reg[(p == NUM_SLOTS - 1) ? p : p + 1];
                end
                else if (is_remove)
                begin
                    if ((HW'(p) >= old_h) && (HW'(p) < top_reg))
                        order_next[p] = order_reg[(p == NUM_SLOTS - 1) ? p : p + 1];
                end
                else if ((HW'(p) > tgt) && (HW'(p) <= top_reg + ONE))
                begin
                    order_next[p] = order_reg[(p == 0) ? 0 : p - 1];
                end
            end
        end
    end

    always_comb
    begin
        top_next = top_reg;
        if (active && is_remove)
            top_next = top_reg - ONE;
        else if (active && is_insert)
            top_next = top_reg + ONE;
    end

    always_comb
    begin
        res.ok         = 1'b0;
        res.slot_out   = cmd.slot;
        res.new_height = NH_HIDDEN;
        res.top_height = 5'(top_next);
        case (cmd.kind)
            CMD_ALLOC:
                res.ok = 1'b1;
            CMD_FAIL:
                res.slot_out = '0;
            CMD_SET:
            begin
                res.ok         = 1'b1;
                res.new_height = 5'(tgt);
            end
            CMD_FREE:
                res.ok = 1'b1;
            CMD_REJECT:
                res.new_height = 5'(old_h);
            CMD_REJECT_OOR:
                res.new_height = NH_HIDDEN;
            default:
                res.ok = 1'b0;
        endcase
    end

    always_comb
    begin
        shown_cnt = '0;
        for (int j = 0; j < NUM_SLOTS; j++)
        begin
            shown_cnt = shown_cnt + (SW + 1)'(h_reg[j] >= 0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < NUM_SLOTS; j++)
            begin
                h_reg[j] <= NEG1;
            end
            top_reg <= NEG1;
        end
        else
        begin
            h_reg   <= h_next;
            top_reg <= top_next;
        end
    end

    always_ff @(posedge clk)
    begin
        order_reg <= order_next;
    end

    `LSOT_ASSERT_ALWAYS(a_top_matches_shown, (int'(shown_cnt) == int'(top_reg) + 1),
        "top height disagrees with number of shown layers")
    `LSOT_ASSERT_SAME(a_alloc_hidden, (res_push && (cmd.kind == CMD_ALLOC)),
        (res.new_height == NH_HIDDEN), "allocated slot not reported hidden")
    `LSOT_ASSERT_NEXT(a_free_no_growth, (cmd_pop && (cmd.kind == CMD_FREE)),
        (top_reg <= $past(top_reg)), "free raised the stack top")

endmodule

// ===== src/layer_stack_order_table.sv =====
// A beat accepted at the input is registered in the command queue; the back end pops and handles it,
// registering its result in the result queue. Throughput: one beat per cycle while results are popped.
// Slot grant and release run in the front; the back end renumbers the whole stack in parallel.
// Reset (rst_n low, asynchronous): all slots free and hidden, stack empty, both queues empty.
// Stack order entries carry no reset; they are written before they are used.
// Top level of the layer stack order table
module layer_stack_order_table #(
    parameter int NUM_SLOTS = lsot_pkg::NUM_SLOTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        op,
    input  logic [3:0]        slot,
    input  logic signed [7:0] requested_height,
    output logic              empty,
    input  logic              pop,
    output logic              ok,
    output logic [3:0]        slot_out,
    output logic signed [4:0] new_height,
    output logic signed [4:0] top_height
);
    import lsot_pkg::*;

    cmd_t cmd_in, cmd_out;
    res_t res_in, res_out;
    logic take;
    logic cmd_empty, cmd_pop;
    logic res_full, res_push;

    assign take = push && !full;

    lsot_front #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .take             (take),
        .op               (op),
        .slot             (slot),
        .requested_height (requested_height),
        .cmd              (cmd_in)
    );

    lsot_fifo #(
        .WIDTH($bits(cmd_t)),
        .DEPTH(CMD_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (cmd_in),
        .full    (full),
        .pop     (cmd_pop),
        .rd_data (cmd_out),
        .empty   (cmd_empty)
    );

    lsot_back #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res       (res_in),
        .res_push  (res_push)
    );

    lsot_fifo #(
        .WIDTH($bits(res_t)),
        .DEPTH(RES_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .pop     (pop),
        .rd_data (res_out),
        .empty   (empty)
    );

    assign ok         = res_out.ok;
    assign slot_out   = res_out.slot_out;
    assign new_height = res_out.new_height;
    assign top_height = res_out.top_height;

endmodule

// ===== sim/tb_layer_stack_order_table.sv =====
// Self-checking testbench for the layer stack order table: directed and random z-order traffic vs predictor
module tb_layer_stack_order_table;
    import lsot_pkg::*;

    localparam int SLOTS       = NUM_SLOTS_DEF;
    localparam int RAND_ITEMS  = 1600;
    localparam int HOLD_CYCLES = 120;

    typedef struct {
        op_t               kind;
        logic [3:0]        slot;
        logic signed [7:0] req;
        bit                wait_idle;   // hold the beat until every result is back
    } layer_cmd_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              push = 1'b0;
    logic              full;
    op_t               op = OP_ALLOC;
    logic [3:0]        slot = 4'd0;
    logic signed [7:0] requested_height = 8'sd0;
    logic              empty;
    logic              pop = 1'b0;
    logic              ok;
    logic [3:0]        slot_out;
    logic signed [4:0] new_height;
    logic signed [4:0] top_height;

    layer_stack_order_table dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .op(op),
        .slot(slot),
        .requested_height(requested_height),
        .empty(empty),
        .pop(pop),
        .ok(ok),
        .slot_out(slot_out),
        .new_height(new_height),
        .top_height(top_height)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // stimulus backlog and outstanding results
    layer_cmd_t cmd_backlog[$];
    res_t       due_results[$];
    bit         gen_used[SLOTS];
    int         queued = 0;

    // predictor state
    bit         slot_taken[SLOTS];
    int         layer_lvl[SLOTS];
    logic [3:0] z_order[SLOTS];
    int         top_lvl = -1;

    int errors = 0;
    int beats_in = 0;
    int results_seen = 0;
    int full_cycles = 0;
    int n_alloc = 0, n_alloc_fail = 0, n_set = 0, n_free = 0, n_reject = 0;
    int tallest = -1;

    task automatic report(string what);
        errors++;
        if (errors <= 30)
            $display("mismatch @%0t: %s", $time, what);
    endtask

    function automatic void seat(int pos, int s);
        z_order[pos] = 4'(s);
        layer_lvl[s] = pos;
    endfunction

    // clamp, then insert / remove / move the layer; neighbours shift by one
    function automatic void restack(int s, int want);
        int was, cap, h;
        was = layer_lvl[s];
        cap = (was >= 0) ? top_lvl : top_lvl + 1;
        if (want > cap)
            want = cap;
        if (want < -1)
            want = -1;
        if (was == want)
            return;
        if (was >= 0 && want >= 0)
        begin
            if (was > want)
            begin
                for (h = was; h > want; h--)
                    seat(h, z_order[h - 1]);
            end
            else
            begin
                for (h = was; h < want; h++)
                    seat(h, z_order[h + 1]);
            end
            seat(want, s);
        end
        else if (was >= 0)
        begin
            // removal shifts from the old height
            for (h = was; h < top_lvl; h++)
                seat(h, z_order[h + 1]);
            top_lvl--;
            layer_lvl[s] = -1;
        end
        else
        begin
            for (h = top_lvl; h >= want; h--)
                seat(h + 1, z_order[h]);
            seat(want, s);
            top_lvl++;
        end
    endfunction

    function automatic res_t apply_layer_op(op_t o, logic [3:0] s, logic signed [7:0] rh);
        res_t r;
        int   i;
        int   s_i;
        s_i = int'(s);
        r.ok = 1'b0;
        r.slot_out = s;
        r.new_height = NH_HIDDEN;
        if (o == OP_ALLOC)
        begin
            n_alloc++;
            r.slot_out = 4'd0;
            for (i = 0; i < SLOTS; i++)
            begin
                if (!slot_taken[i])
                begin
                    slot_taken[i] = 1'b1;
                    layer_lvl[i] = -1;
                    r.ok = 1'b1;
                    r.slot_out = 4'(i);
                    break;
                end
            end
            if (!r.ok)
                n_alloc_fail++;
        end
        else if (o == OP_NONE || !slot_taken[s_i])
        begin
            n_reject++;
            r.new_height = 5'(layer_lvl[s_i]);
        end
        else if (o == OP_SET)
        begin
            n_set++;
            restack(s_i, int'(rh));
            r.ok = 1'b1;
            r.new_height = 5'(layer_lvl[s_i]);
        end
        else
        begin
            n_free++;
            if (layer_lvl[s_i] >= 0)
                restack(s_i, -1);
            slot_taken[s_i] = 1'b0;
            layer_lvl[s_i] = -1;
            r.ok = 1'b1;
        end
        r.top_height = 5'(top_lvl);
        if (top_lvl > tallest)
            tallest = top_lvl;
        return r;
    endfunction

    function automatic int sender_gap();
        int r;
        if ((beats_in / 128) % 3 == 2)
            return 0;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    function automatic int receiver_gap();
        int r;
        if ((results_seen / 100) % 4 == 1)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    // generator keeps its own allocation map so that sequences address live slots
    function automatic void add(op_t o, int s, int r);
        layer_cmd_t c;
        int         i;
        c.kind = o;
        c.slot = 4'(s);
        c.req = 8'(r);
        c.wait_idle = (queued == 600 || queued == 1300);
        if (o == OP_ALLOC)
        begin
            for (i = 0; i < SLOTS; i++)
            begin
                if (!gen_used[i])
                begin
                    gen_used[i] = 1'b1;
                    break;
                end
            end
        end
        else if (o == OP_FREE)
            gen_used[s] = 1'b0;
        cmd_backlog.push_back(c);
        queued++;
    endfunction

    function automatic int any_used();
        int pool[$];
        foreach (gen_used[i])
            if (gen_used[i])
                pool.push_back(i);
        if (pool.size() == 0)
            return -1;
        return pool[$urandom_range(pool.size() - 1)];
    endfunction

    function automatic int free_count();
        int n;
        n = 0;
        foreach (gen_used[i])
            if (!gen_used[i])
                n++;
        return n;
    endfunction

    function automatic int rand_height();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return -1;
        if (r < 25)
            return int'($signed(8'($urandom)));
        return $urandom_range(17);
    endfunction

    // sender
    int         tx_gap = 0;
    layer_cmd_t cur_cmd;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && full)
                full_cycles++;
            if (!push || !full)
            begin
                if (push)
                begin
                    beats_in++;
                    due_results.push_back(apply_layer_op(op, slot, requested_height));
                end
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    push <= 1'b0;
                end
                else if (cmd_backlog.size() > 0 &&
                         !(cmd_backlog[0].wait_idle && due_results.size() != 0))
                begin
                    cur_cmd = cmd_backlog.pop_front();
                    push <= 1'b1;
                    op <= cur_cmd.kind;
                    slot <= cur_cmd.slot;
                    requested_height <= cur_cmd.req;
                    tx_gap = sender_gap();
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // receiver and checker
    int   rx_stall = 0;
    int   rx_hold = 0;
    res_t exp_r;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                results_seen++;
                if (due_results.size() == 0)
                    report("result beat with nothing outstanding");
                else
                begin
                    exp_r = due_results.pop_front();
                    if (ok !== exp_r.ok)
                        report($sformatf("beat %0d ok %b, expected %b",
                                         results_seen, ok, exp_r.ok));
                    if (slot_out !== exp_r.slot_out)
                        report($sformatf("beat %0d slot_out %0d, expected %0d",
                                         results_seen, slot_out, exp_r.slot_out));
                    if (new_height !== exp_r.new_height)
                        report($sformatf("beat %0d new_height %0d, expected %0d",
                                         results_seen, new_height, exp_r.new_height));
                    if (top_height !== exp_r.top_height)
                        report($sformatf("beat %0d top_height %0d, expected %0d",
                                         results_seen, top_height, exp_r.top_height));
                end
                rx_stall = receiver_gap();
                // long hold-off so the block backs up and raises full
                if (results_seen == 250 || results_seen == 1000)
                    rx_hold = HOLD_CYCLES;
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                pop <= 1'b0;
            end
            else if (rx_stall > 0)
            begin
                rx_stall--;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    initial
    begin
        #5000000;
        $display("timeout: %0d of %0d beats in, %0d results outstanding",
                 beats_in, queued, due_results.size());
        $display("** layer_stack_order_table: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        int kind, cnt, k, s, r;
        for (k = 0; k < SLOTS; k++)
        begin
            slot_taken[k] = 1'b0;
            layer_lvl[k] = -1;
            gen_used[k] = 1'b0;
        end

        // directed: rejects, clamping both ways, insert, move, hide, free shown and hidden
        add(OP_SET, 5, 3);
        add(OP_FREE, 15, 0);
        add(OP_NONE, 0, -1);
        add(OP_ALLOC, 0, 0);
        add(OP_ALLOC, 0, 0);
        add(OP_SET, 0, 127);
        add(OP_SET, 1, -128);
        add(OP_SET, 1, 0);
        add(OP_SET, 1, 127);
        add(OP_NONE, 1, 5);
        add(OP_ALLOC, 0, 0);
        add(OP_SET, 2, 1);
        add(OP_SET, 0, -1);
        add(OP_FREE, 1, 0);
        add(OP_FREE, 0, 0);
        add(OP_SET, 2, -5);
        add(OP_SET, 2, -1);
        add(OP_FREE, 2, 0);
        add(OP_FREE, 2, 0);
        add(OP_NONE, 15, -128);

        while (queued < RAND_ITEMS + 20)
        begin
            kind = $urandom_range(99);
            if (kind < 50)
            begin
                cnt = $urandom_range(60, 20);
                repeat (cnt)
                begin
                    r = $urandom_range(99);
                    s = any_used();
                    if (r < 65 && s >= 0)
                        add(OP_SET, s, rand_height());
                    else if (r >= 80 && r < 95 && s >= 0)
                        add(OP_FREE, s, rand_height());
                    else if (r >= 95)
                        add(OP_NONE, $urandom_range(SLOTS - 1), rand_height());
                    else
                        add(OP_ALLOC, $urandom_range(SLOTS - 1), rand_height());
                end
            end
            else if (kind < 65)
            begin
                // fill the pool and run past it
                cnt = free_count() + $urandom_range(3, 1);
                repeat (cnt)
                    add(OP_ALLOC, $urandom_range(SLOTS - 1), int'($signed(8'($urandom))));
            end
            else if (kind < 75)
            begin
                s = any_used();
                while (s >= 0)
                begin
                    add(OP_FREE, s, rand_height());
                    s = any_used();
                end
            end
            else
            begin
                cnt = $urandom_range(15, 5);
                repeat (cnt)
                    add(op_t'($urandom_range(3)), $urandom_range(SLOTS - 1),
                        int'($signed(8'($urandom))));
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (beats_in < queued || due_results.size() != 0);
        repeat (10) @(posedge clk);

        $display("covered %0d beats: alloc %0d (%0d refused), set-height %0d, free %0d, rejected %0d",
                 beats_in, n_alloc, n_alloc_fail, n_set, n_free, n_reject);
        $display("tallest stack top %0d, input held by full on %0d cycles, %0d results checked",
                 tallest, full_cycles, results_seen);
        if (errors == 0)
            $display("** layer_stack_order_table: PASSED **");
        else
            $display("** layer_stack_order_table: FAILED **");
        $finish;
    end
endmodule
